// ===== hdl/c8ic_pkg.sv =====
package c8ic_pkg;

  localparam int MemBytes   = 4096;
  localparam int StackDepth = 16;
  localparam int FontBase   = 'h50;
  localparam int FontBytes  = 80;
  localparam logic [11:0] PcReset = 12'h200;

  typedef enum logic [1:0] {
    CMD_EXEC  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT,
    S_FETCH_HI,
    S_FETCH_LO,
    S_FETCH_END,
    S_DECODE,
    S_CLEAR,
    S_DRAW_RD,
    S_DRAW_ROW,
    S_BCD,
    S_STORE,
    S_LOAD_RD,
    S_LOAD_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [11:0] pc_after;
    logic [15:0] opcode_run;
    logic [63:0] row_pixels;
    logic        waiting_key;
    logic        sound_on;
    logic        stack_fault;
  } result_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] load_address;
    logic [7:0]  load_byte;
    logic [4:0]  row_select;
    logic [15:0] keys_down;
    logic [7:0]  random_byte;
  } request_t;

  function automatic logic [7:0] font_byte(input logic [6:0] idx);
    logic [7:0] glyphs [0:79];
    glyphs = '{
      8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
      8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
      8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
      8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
      8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
      8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
      8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
      8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80};
    if (idx < 7'(FontBytes)) return glyphs[idx];
    return 8'h00;
  endfunction

endpackage

// ===== hdl/c8ic_if.sv =====
interface c8ic_if #(parameter int W = 1) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/c8ic_mem.sv =====
module c8ic_mem
  import c8ic_pkg::*;
#(
  parameter int MEM_BYTES = MemBytes
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(MEM_BYTES)-1:0]  waddr,
  input  logic [7:0]                    wdata,
  input  logic [$clog2(MEM_BYTES)-1:0]  raddr,
  output logic [7:0]                    rdata
);
  logic [7:0] mem [0:MEM_BYTES-1];

  // write port, registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/c8ic_alu.sv =====
module c8ic_alu (
  input  logic [3:0] op,
  input  logic [7:0] a,
  input  logic [7:0] b,
  output logic [7:0] res,
  output logic       flag,
  output logic       flag_we
);
  logic [8:0] sum;
  always_comb begin
    sum = {1'b0, a} + {1'b0, b};
    res = a;
    flag = 1'b0;
    flag_we = 1'b0;
    case (op)
      4'h0: res = b;
      4'h1: res = a | b;
      4'h2: res = a & b;
      4'h3: res = a ^ b;
      4'h4: begin res = sum[7:0]; flag = sum[8]; flag_we = 1'b1; end
      4'h5: begin res = a - b; flag = (a >= b); flag_we = 1'b1; end
      4'h6: begin res = a >> 1; flag = a[0]; flag_we = 1'b1; end
      4'h7: begin res = b - a; flag = (b >= a); flag_we = 1'b1; end
      4'hE: begin res = a << 1; flag = a[7]; flag_we = 1'b1; end
      default: res = a;
    endcase
  end
endmodule

// ===== hdl/chip8_instruction_core_top.sv =====
// channel  dir  payload
// req      in   command, load_address, load_byte, row_select, keys_down, random_byte
// rsp      out  pc_after, opcode_run, row_pixels, waiting_key, sound_on, stack_fault
// Tick, write and read pass from idle straight to the done state. Execute
// fetches the opcode bytes through the single memory port and decodes it;
// clear, draw, BCD, FX55 and FX65 then step one row, digit or register at a time.
// After reset a pass clears memory and loads the font; no request is
// taken meanwhile. A result waits in the output register.
module chip8_instruction_core_top
  import c8ic_pkg::*;
#(
  parameter int MEM_BYTES   = MemBytes,
  parameter int STACK_DEPTH = StackDepth
) (
  input logic clk,
  input logic rst,
  c8ic_if.sink   req,
  c8ic_if.source rsp
);
  localparam int AW = $clog2(MEM_BYTES);
  localparam int SW = $clog2(STACK_DEPTH + 1);
  localparam int SI = $clog2(STACK_DEPTH);

  state_t state, state_next;
  request_t r;
  request_t req_in;
  result_t  res_q;
  logic rsp_valid;

  logic [7:0]  v [0:15];
  logic [11:0] pc;
  logic [15:0] ir;
  logic [11:0] stk [0:STACK_DEPTH-1];
  logic [SW-1:0] sp;
  logic [7:0]  dt, st;
  logic [63:0] fb [0:31];
  logic [15:0] op;
  logic [AW:0] cnt;
  logic [7:0]  dx, dy;
  logic        waiting, fault;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  assign req_in = request_t'(req.payload);

  c8ic_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata));

  logic [7:0] alu_res;
  logic alu_flag, alu_fwe;
  c8ic_alu u_alu (
    .op(op[3:0]), .a(v[op[11:8]]), .b(v[op[7:4]]),
    .res(alu_res), .flag(alu_flag), .flag_we(alu_fwe));

  logic [7:0] vx, vy;
  assign vx = v[op[11:8]];
  assign vy = v[op[7:4]];

  assign req.ready = (state == S_IDLE) && !rsp_valid;
  assign rsp.valid = rsp_valid;
  assign rsp.payload = res_q;

  // sprite row placement
  logic [4:0]  py;
  logic [63:0] spr, rot;
  assign py  = dy[4:0] + cnt[4:0];
  assign spr = {rdata, 56'd0};
  assign rot = (spr >> dx[5:0]) | (spr << (7'd64 - {1'b0, dx[5:0]}));

  // lowest pressed key
  logic [3:0] low_key;
  always_comb begin
    low_key = 4'd0;
    for (int j = 15; j >= 0; j--) if (r.keys_down[j]) low_key = 4'(j);
  end

  // split VX into hundreds, tens and ones by compare and subtract
  logic [7:0] bcd_h, bcd_t, bcd_o, bcd_r;
  always_comb begin
    bcd_h = 8'd0;
    bcd_r = vx;
    if (vx >= 8'd200) begin
      bcd_h = 8'd2;
      bcd_r = vx - 8'd200;
    end else if (vx >= 8'd100) begin
      bcd_h = 8'd1;
      bcd_r = vx - 8'd100;
    end
    bcd_t = 8'd0;
    for (int j = 1; j < 10; j++) if (bcd_r >= 8'(10 * j)) bcd_t = 8'(j);
    bcd_o = bcd_r - {bcd_t[4:0], 3'b000} - {bcd_t[6:0], 1'b0};
  end

  // memory addressing
  always_comb begin
    we = 1'b0;
    waddr = AW'(cnt);
    wdata = 8'd0;
    raddr = AW'(ir + 16'(cnt));
    case (state)
      S_INIT: begin
        we = 1'b1;
        wdata = (cnt[AW-1:0] >= AW'(FontBase) && cnt[AW-1:0] < AW'(FontBase + FontBytes))
          ? font_byte(7'(cnt[AW-1:0] - AW'(FontBase))) : 8'd0;
      end
      S_FETCH_HI: raddr = AW'(pc);
      S_FETCH_LO: raddr = AW'(pc + 12'd1);
      S_BCD: begin
        we = 1'b1;
        waddr = AW'(ir + 16'(cnt));
        wdata = (cnt == 0) ? bcd_h : (cnt == 1) ? bcd_t : bcd_o;
      end
      S_STORE: begin
        we = 1'b1;
        waddr = AW'(ir + 16'(cnt));
        wdata = v[cnt[3:0]];
      end
      default: ;
    endcase
    if (state == S_IDLE && req.valid && req.ready &&
        req_in.command == CMD_WRITE) begin
      we = 1'b1;
      waddr = AW'(req_in.load_address);
      wdata = req_in.load_byte;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: if (cnt == (AW+1)'(MEM_BYTES - 1)) state_next = S_IDLE;
      S_IDLE: if (req.valid && req.ready)
        state_next = (req_in.command == CMD_EXEC) ? S_FETCH_HI : S_DONE;
      S_FETCH_HI: state_next = S_FETCH_LO;
      S_FETCH_LO: state_next = S_FETCH_END;
      S_FETCH_END: state_next = S_DECODE;
      S_DECODE: begin
        state_next = S_DONE;
        if (op[15:12] == 4'hD && op[3:0] != 0) state_next = S_DRAW_RD;
        if (op == 16'h00E0) state_next = S_CLEAR;
        if (op[15:12] == 4'hF && op[7:0] == 8'h33) state_next = S_BCD;
        if (op[15:12] == 4'hF && op[7:0] == 8'h55) state_next = S_STORE;
        if (op[15:12] == 4'hF && op[7:0] == 8'h65) state_next = S_LOAD_RD;
      end
      S_CLEAR: if (cnt[4:0] == 5'd31) state_next = S_DONE;
      S_DRAW_RD: state_next = S_DRAW_ROW;
      S_DRAW_ROW: state_next = (cnt[3:0] == op[3:0] - 4'd1) ? S_DONE : S_DRAW_RD;
      S_BCD: if (cnt == 2) state_next = S_DONE;
      S_STORE: if (cnt[3:0] == op[11:8]) state_next = S_DONE;
      S_LOAD_RD: state_next = S_LOAD_WR;
      S_LOAD_WR: state_next = (cnt[3:0] == op[11:8]) ? S_DONE : S_LOAD_RD;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; pc <= PcReset; ir <= '0; sp <= '0; dt <= '0; st <= '0;
      rsp_valid <= 1'b0; op <= '0; waiting <= 1'b0; fault <= 1'b0;
      dx <= '0; dy <= '0;
      for (int j = 0; j < 16; j++) v[j] <= '0;
      for (int j = 0; j < 32; j++) fb[j] <= '0;
    end else begin
      if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;
      case (state)
        S_INIT: cnt <= cnt + 1'b1;
        S_IDLE: if (req.valid && req.ready) begin
          r <= req_in;
          op <= '0; cnt <= '0; waiting <= 1'b0; fault <= 1'b0;
          if (req_in.command == CMD_TICK) begin
            if (dt != 0) dt <= dt - 8'd1;
            if (st != 0) st <= st - 8'd1;
          end
        end
        S_FETCH_HI: ;
        S_FETCH_LO: op[15:8] <= rdata;
        S_FETCH_END: op[7:0] <= rdata;
        S_DECODE: begin
          pc <= pc + 12'd2;
          case (op[15:12])
            4'h0: if (op == 16'h00EE) begin
              if (sp == 0) fault <= 1'b1;
              else begin sp <= sp - 1'b1; pc <= stk[SI'(sp - 1'b1)]; end
            end
            4'h1: pc <= op[11:0];
            4'h2: if (sp >= SW'(STACK_DEPTH)) fault <= 1'b1;
              else begin
                stk[SI'(sp)] <= pc + 12'd2; sp <= sp + 1'b1; pc <= op[11:0];
              end
            4'h3: if (vx == op[7:0]) pc <= pc + 12'd4;
            4'h4: if (vx != op[7:0]) pc <= pc + 12'd4;
            4'h5: if (vx == vy) pc <= pc + 12'd4;
            4'h6: v[op[11:8]] <= op[7:0];
            4'h7: v[op[11:8]] <= vx + op[7:0];
            4'h8: begin
              v[op[11:8]] <= alu_res;
              if (alu_fwe) v[15] <= {7'd0, alu_flag};
            end
            4'h9: if (vx != vy) pc <= pc + 12'd4;
            4'hA: ir <= {4'd0, op[11:0]};
            4'hB: pc <= op[11:0] + {4'd0, v[0]};
            4'hC: v[op[11:8]] <= r.random_byte & op[7:0];
            4'hD: begin
              v[15] <= 8'd0;
              dx <= vx;
              dy <= vy;
            end
            4'hE: begin
              if ((op[7:0] == 8'h9E && r.keys_down[vx[3:0]]) ||
                  (op[7:0] == 8'hA1 && !r.keys_down[vx[3:0]])) pc <= pc + 12'd4;
            end
            default: case (op[7:0])
              8'h07: v[op[11:8]] <= dt;
              8'h0A: if (r.keys_down == 0) waiting <= 1'b1;
                else v[op[11:8]] <= {4'd0, low_key};
              8'h15: dt <= vx;
              8'h18: st <= vx;
              8'h1E: ir <= ir + {8'd0, vx};
              8'h29: ir <= 16'h50 + {6'd0, vx, 2'b00} + {8'd0, vx};
              default: ;
            endcase
          endcase
          if (op[15:12] == 4'hF && op[7:0] == 8'h0A && r.keys_down == 0) pc <= pc;
        end
        S_CLEAR: begin fb[cnt[4:0]] <= '0; cnt <= cnt + 1'b1; end
        S_DRAW_ROW: begin
          if ((fb[py] & rot) != 0) v[15] <= 8'd1;
          fb[py] <= fb[py] ^ rot;
          cnt <= cnt + 1'b1;
        end
        S_BCD: cnt <= cnt + 1'b1;
        S_STORE: cnt <= cnt + 1'b1;
        S_LOAD_WR: begin v[cnt[3:0]] <= rdata; cnt <= cnt + 1'b1; end
        S_DONE: begin
          rsp_valid <= 1'b1;
          res_q.pc_after <= pc;
          res_q.opcode_run <= op;
          res_q.row_pixels <= (r.command == CMD_READ) ? fb[r.row_select] : 64'd0;
          res_q.waiting_key <= waiting;
          res_q.sound_on <= (st != 0);
          res_q.stack_fault <= fault;
        end
        default: ;
      endcase
    end
  end
endmodule
